// ----- src/sts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, state encoding and clipping helper for the triangular solver.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int VALUE_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int SUM_BITS   = VALUE_BITS + 16;
	localparam int IDX_BITS   = 10;
	localparam int DEPTH      = 1 << IDX_BITS;
	localparam int TAG_BITS   = 8;
	localparam int WORD_BITS  = TAG_BITS + VALUE_BITS;
	localparam int DVD_BITS   = SUM_BITS + FRAC_BITS;
	localparam int CNT_BITS   = $clog2(DVD_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_MUL,
		ST_ACC,
		ST_NUM,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                  flag;
		logic [SUM_BITS-1:0]   value;
	} clip_t;

	function automatic clip_t clip_sum(input logic signed [SUM_BITS+1:0] v);
		clip_t                 r;
		logic signed [SUM_BITS+1:0] hi;
		logic signed [SUM_BITS+1:0] lo;
		hi = (SUM_BITS+2)'((64'd1 << (SUM_BITS - 1)) - 64'd1);
		lo = -hi - (SUM_BITS+2)'(1);
		r.flag  = 1'b0;
		r.value = v[SUM_BITS-1:0];
		if (v > hi) begin
			r.flag  = 1'b1;
			r.value = hi[SUM_BITS-1:0];
		end else if (v < lo) begin
			r.flag  = 1'b1;
			r.value = lo[SUM_BITS-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/sts_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_store
// Solution memory: one write port, one read port, registered read data.
// Each word holds a solve tag above the Q16.16 value.
// ----------------------------------------------------------------------------
module sts_store
	import sts_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [IDX_BITS-1:0]  wr_addr,
	input  wire logic [WORD_BITS-1:0] wr_data,
	input  wire logic [IDX_BITS-1:0]  rd_addr,
	output logic      [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ----- src/sts_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sts_div
	import sts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DVD_BITS-1:0]   dividend,
	input  wire logic [VALUE_BITS-1:0] divisor,
	output logic                       done,
	output logic      [DVD_BITS-1:0]   quotient
);

	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [DVD_BITS-1:0]   quo_q;
	logic [VALUE_BITS-1:0] dsr_q;
	logic [VALUE_BITS:0]   trial;

	assign trial    = {rem_q, quo_q[DVD_BITS-1]};
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(DVD_BITS);
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= VALUE_BITS'(trial - {1'b0, dsr_q});
				quo_q <= {quo_q[DVD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[VALUE_BITS-1:0];
				quo_q <= {quo_q[DVD_BITS-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/sparse_triangular_solve_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_triangular_solve_top
// Row-by-row sparse triangular solve in Q16.16 over a tagged solution memory.
// ----------------------------------------------------------------------------
// A word without row end goes through accept, memory read, multiply and
// accumulate; a row end adds the numerator step, the bit-serial divider (not
// for a zero diagonal) and the output step, which waits for out_ready. No new
// word is taken before the last is through. A new solve bumps the solve tag;
// every 255th one sweeps the memory; after reset the same sweep runs first.
// ----------------------------------------------------------------------------
module sparse_triangular_solve_top
	import sts_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         first_of_solve,
	input  wire logic                         has_coeff,
	input  wire logic [IDX_BITS-1:0]          column,
	input  wire logic signed [VALUE_BITS-1:0] coeff,
	input  wire logic                         last_of_row,
	input  wire logic [IDX_BITS-1:0]          row,
	input  wire logic signed [VALUE_BITS-1:0] rhs,
	input  wire logic signed [VALUE_BITS-1:0] diag,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [IDX_BITS-1:0]               out_row,
	output logic signed [VALUE_BITS-1:0]      solution,
	output logic                              zero_diag,
	output logic                              saturated
);

	state_t state_q, state_d;

	logic [TAG_BITS-1:0]          epoch_q;
	logic [IDX_BITS-1:0]          clr_q;
	logic                         pend_q;
	logic                         has_q, last_q;
	logic [IDX_BITS-1:0]          col_q, row_q;
	logic signed [VALUE_BITS-1:0] coeff_q, rhs_q, diag_q;
	logic signed [SUM_BITS-1:0]   sum_q;
	logic                         rsat_q;
	logic signed [2*VALUE_BITS-1:0] prod_q;
	logic                         neg_q, zd_q, nsat_q;

	logic                         ovalid_q, ozd_q, osat_q;
	logic [IDX_BITS-1:0]          orow_q;
	logic [VALUE_BITS-1:0]        osol_q;

	logic                         wr_en;
	logic [IDX_BITS-1:0]          wr_addr;
	logic [WORD_BITS-1:0]         wr_data;
	logic [WORD_BITS-1:0]         rd_data;
	logic signed [VALUE_BITS-1:0] xval;

	logic                         div_start, div_done;
	logic [DVD_BITS-1:0]          dividend, quotient;
	logic [VALUE_BITS-1:0]        dmag;

	logic                         accept, fin_go;
	logic [2*VALUE_BITS-1:0]      pmag;
	logic [SUM_BITS-1:0]          rnd;
	clip_t                        acc_c, num_c;
	logic [SUM_BITS-1:0]          nmag;
	logic signed [VALUE_BITS-1:0] qval;
	logic                         qsat;

	localparam logic [DVD_BITS-1:0] VMAX = DVD_BITS'((64'd1 << (VALUE_BITS - 1)) - 64'd1);

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign fin_go    = (state_q == ST_FIN) && (!ovalid_q || out_ready);

	assign out_valid = ovalid_q;
	assign out_row   = orow_q;
	assign solution  = osol_q;
	assign zero_diag = ozd_q;
	assign saturated = osat_q;

	sts_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (col_q),
		.rd_data (rd_data)
	);

	sts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (dmag),
		.done     (div_done),
		.quotient (quotient)
	);

	assign xval = (rd_data[WORD_BITS-1:VALUE_BITS] == epoch_q) ?
		rd_data[VALUE_BITS-1:0] : '0;

	assign pmag = prod_q[2*VALUE_BITS-1] ? 64'(-prod_q) : prod_q;
	assign rnd  = SUM_BITS'((pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	assign acc_c = clip_sum(prod_q[2*VALUE_BITS-1] ?
		{{2{sum_q[SUM_BITS-1]}}, sum_q} + {2'b00, rnd} :
		{{2{sum_q[SUM_BITS-1]}}, sum_q} - {2'b00, rnd});
	assign num_c = clip_sum({{2{sum_q[SUM_BITS-1]}}, sum_q}
		+ (SUM_BITS+2)'(rhs_q));
	assign nmag = num_c.value[SUM_BITS-1] ? SUM_BITS'(-num_c.value) : num_c.value;
	assign dividend  = {nmag, {FRAC_BITS{1'b0}}};
	assign dmag      = diag_q[VALUE_BITS-1] ? VALUE_BITS'(-diag_q) : diag_q;
	assign div_start = (state_q == ST_NUM) && (diag_q != '0);

	always_comb begin
		qsat = 1'b0;
		qval = '0;
		if (!zd_q) begin
			if (!neg_q && quotient > VMAX) begin
				qsat = 1'b1;
				qval = VMAX[VALUE_BITS-1:0];
			end else if (neg_q && quotient > VMAX + DVD_BITS'(1)) begin
				qsat = 1'b1;
				qval = ~VMAX[VALUE_BITS-1:0];
			end else if (neg_q) begin
				qval = -quotient[VALUE_BITS-1:0];
			end else begin
				qval = quotient[VALUE_BITS-1:0];
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = row_q;
		wr_data = {epoch_q, qval};
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (fin_go) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (first_of_solve && epoch_q == '1) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = pend_q ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: state_d = ST_MUL;
			ST_MUL:  state_d = ST_ACC;
			ST_ACC:  state_d = last_q ? ST_NUM : ST_IDLE;
			ST_NUM:  state_d = (diag_q == '0) ? ST_FIN : ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			epoch_q  <= TAG_BITS'(1);
			clr_q    <= '0;
			pend_q   <= 1'b0;
			sum_q    <= '0;
			rsat_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_BITS'(1);
				if (clr_q == '1) begin
					epoch_q <= TAG_BITS'(1);
					pend_q  <= 1'b0;
				end
			end
			if (accept) begin
				if (first_of_solve) begin
					sum_q  <= '0;
					rsat_q <= 1'b0;
					if (epoch_q == '1) begin
						pend_q <= 1'b1;
					end else begin
						epoch_q <= epoch_q + TAG_BITS'(1);
					end
				end
			end
			if (state_q == ST_ACC && has_q) begin
				sum_q <= acc_c.value;
				if (acc_c.flag) begin
					rsat_q <= 1'b1;
				end
			end
			if (fin_go) begin
				sum_q    <= '0;
				rsat_q   <= 1'b0;
				ovalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			has_q   <= has_coeff;
			last_q  <= last_of_row;
			col_q   <= column;
			row_q   <= row;
			coeff_q <= coeff;
			rhs_q   <= rhs;
			diag_q  <= diag;
		end
		if (state_q == ST_MUL) begin
			prod_q <= coeff_q * xval;
		end
		if (state_q == ST_NUM) begin
			neg_q  <= num_c.value[SUM_BITS-1] ^ diag_q[VALUE_BITS-1];
			zd_q   <= (diag_q == '0);
			nsat_q <= rsat_q || num_c.flag;
		end
		if (fin_go) begin
			orow_q <= row_q;
			osol_q <= qval;
			ozd_q  <= zd_q;
			osat_q <= nsat_q || qsat;
		end
	end

endmodule
`default_nettype wire

// ----- test/sparse_triangular_solve_top_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_triangular_solve_top_tb
// Streams whole solves of random sparse triangular rows into the solver and
// compares every emitted unknown with a fixed-point prediction of the solve.
// ----------------------------------------------------------------------------
module sparse_triangular_solve_top_tb
	import sts_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic                         first;
		logic                         has_c;
		logic [IDX_BITS-1:0]          col;
		logic signed [VALUE_BITS-1:0] cf;
		logic                         last;
		logic [IDX_BITS-1:0]          rw;
		logic signed [VALUE_BITS-1:0] rh;
		logic signed [VALUE_BITS-1:0] dg;
		bit                           pause;
	} word_t;

	typedef struct {
		logic [IDX_BITS-1:0]          rw;
		logic signed [VALUE_BITS-1:0] x;
		logic                         zd;
		logic                         sat;
	} sol_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic first_of_solve = 1'b0;
	logic has_coeff = 1'b0;
	logic [IDX_BITS-1:0] column = '0;
	logic signed [VALUE_BITS-1:0] coeff = '0;
	logic last_of_row = 1'b0;
	logic [IDX_BITS-1:0] row = '0;
	logic signed [VALUE_BITS-1:0] rhs = '0;
	logic signed [VALUE_BITS-1:0] diag = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IDX_BITS-1:0] out_row;
	logic signed [VALUE_BITS-1:0] solution;
	logic zero_diag;
	logic saturated;

	sparse_triangular_solve_top i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	word_t pending_words[$];
	sol_t  expected_solutions[$];
	int    errors = 0;
	bit    stim_done = 1'b0;
	int    hold_off = 0;

	// predictor state
	logic signed [VALUE_BITS-1:0] x_store[DEPTH];
	bit                           x_valid[DEPTH];
	logic signed [63:0]           acc;
	bit                           acc_sat;

	function automatic logic signed [63:0] clip48(input logic signed [63:0] v, ref bit f);
		logic signed [63:0] hi;
		hi = (64'sd1 <<< (SUM_BITS - 1)) - 1;
		if (v > hi) begin
			f = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			f = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	task automatic solve_word(input word_t w);
		logic signed [63:0] p, xv, num;
		logic [63:0] mag, qm, dm;
		logic signed [63:0] q;
		bit s, neg;
		sol_t r;
		if (w.first) begin
			foreach (x_valid[i]) x_valid[i] = 1'b0;
			acc = 0;
			acc_sat = 1'b0;
		end
		if (w.has_c) begin
			xv = x_valid[w.col] ? 64'(x_store[w.col]) : 64'sd0;
			p = 64'(w.cf) * xv;
			mag = p < 0 ? -p : p;
			mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			p = p < 0 ? -$signed(mag) : $signed(mag);
			acc = clip48(acc - p, acc_sat);
		end
		if (!w.last) return;
		s = acc_sat;
		num = clip48(acc + 64'(w.rh), s);
		q = 0;
		r.zd = (w.dg == 0);
		if (!r.zd) begin
			mag = num < 0 ? -num : num;
			dm = w.dg < 0 ? -64'(w.dg) : 64'(w.dg);
			qm = (mag << FRAC_BITS) / dm;
			neg = (num < 0) != (w.dg < 0);
			if (!neg && qm > 64'h7fff_ffff) begin
				s = 1'b1;
				q = 64'h7fff_ffff;
			end else if (neg && qm > 64'h8000_0000) begin
				s = 1'b1;
				q = -64'sh8000_0000;
			end else q = neg ? -$signed(qm) : $signed(qm);
		end
		x_store[w.rw] = q[VALUE_BITS-1:0];
		x_valid[w.rw] = 1'b1;
		acc = 0;
		acc_sat = 1'b0;
		r.rw = w.rw;
		r.x = q[VALUE_BITS-1:0];
		r.sat = s;
		expected_solutions.push_back(r);
	endtask

	function automatic logic signed [VALUE_BITS-1:0] rand_val(input int mode);
		case (mode)
			0: return $urandom();
			1: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
			2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
		endcase
	endfunction

	function automatic word_t blank_word();
		word_t w;
		w.first = 1'b0;
		w.has_c = 1'b0;
		w.col = IDX_BITS'($urandom());
		w.cf = $urandom();
		w.last = 1'b0;
		w.rw = IDX_BITS'($urandom());
		w.rh = $urandom();
		w.dg = $urandom();
		w.pause = 1'b0;
		return w;
	endfunction

	// a full solve: rows in order, nonzeros mostly at already solved columns
	task automatic add_solve(input int nrows, input bit upper, input int mode);
		int base, r, k, nnz;
		word_t w;
		bit started;
		base = $urandom_range(0, DEPTH - nrows);
		started = 1'b0;
		for (int i = 0; i < nrows; i++) begin
			r = upper ? base + nrows - 1 - i : base + i;
			nnz = (i == 0) ? 0 : $urandom_range(0, 3);
			for (k = 0; k < nnz; k++) begin
				w = blank_word();
				w.first = !started;
				started = 1'b1;
				w.has_c = 1'b1;
				w.col = IDX_BITS'(upper ? r + $urandom_range(1, i) : r - $urandom_range(1, i));
				if ($urandom_range(0, 15) == 0) w.col = IDX_BITS'($urandom());
				w.cf = rand_val(mode);
				pending_words.push_back(w);
			end
			w = blank_word();
			w.first = !started;
			started = 1'b1;
			w.last = 1'b1;
			w.has_c = (i > 0) && $urandom_range(0, 3) == 0;
			w.col = IDX_BITS'(upper ? r + 1 : r - 1);
			w.cf = rand_val(mode);
			w.rw = IDX_BITS'(r);
			w.rh = rand_val(mode);
			w.dg = $urandom_range(0, 15) == 0 ? 32'sd0 : rand_val($urandom_range(1, 3));
			pending_words.push_back(w);
			if ($urandom_range(0, 7) == 0) begin
				w = blank_word();
				pending_words.push_back(w);
			end
		end
	endtask

	initial begin
		word_t w;
		int n;
		foreach (x_valid[i]) x_valid[i] = 1'b0;
		acc = 0;
		acc_sat = 1'b0;
		// directed: extremes, zero diagonal, empty word, coefficient on row end
		w = blank_word();
		w.first = 1'b1;
		w.last = 1'b1;
		w.rw = IDX_BITS'(0);
		w.rh = 32'h7fff_ffff;
		w.dg = 32'h0000_0001;
		pending_words.push_back(w);
		w = blank_word();
		w.last = 1'b1;
		w.rw = IDX_BITS'(1023);
		w.rh = 32'h8000_0000;
		w.dg = 32'h7fff_ffff;
		pending_words.push_back(w);
		w = blank_word();
		w.last = 1'b1;
		w.rw = IDX_BITS'(1);
		w.rh = 32'h0003_0000;
		w.dg = 32'sd0;
		pending_words.push_back(w);
		w = blank_word();
		pending_words.push_back(w);
		for (int i = 0; i < 4; i++) begin
			w = blank_word();
			w.has_c = 1'b1;
			w.col = IDX_BITS'(0);
			w.cf = 32'h7fff_ffff;
			pending_words.push_back(w);
		end
		w = blank_word();
		w.has_c = 1'b1;
		w.col = IDX_BITS'(1023);
		w.cf = 32'h8000_0000;
		w.last = 1'b1;
		w.rw = IDX_BITS'(2);
		w.rh = 32'h8000_0000;
		w.dg = 32'h8000_0000;
		pending_words.push_back(w);
		w = blank_word();
		w.has_c = 1'b1;
		w.col = IDX_BITS'(2);
		w.cf = 32'hffff_ffff;
		w.last = 1'b1;
		w.rw = IDX_BITS'(3);
		w.rh = 32'h0000_0000;
		w.dg = 32'hffff_ffff;
		pending_words.push_back(w);
		// wait for every result before the random part
		w = blank_word();
		w.first = 1'b1;
		w.pause = 1'b1;
		pending_words.push_back(w);
		n = 0;
		while (pending_words.size() < 520) begin
			add_solve($urandom_range(0, 9) == 0 ? $urandom_range(10, 20) : $urandom_range(2, 6),
				$urandom_range(0, 1), $urandom_range(0, 3));
			if (++n == 20) pending_words[$].pause = 1'b1;
		end
	end

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50) return 0;
		if (k < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	// sender
	int gap = 0;
	bit waiting = 1'b0;
	word_t w_drive;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap <= 0;
			waiting <= 1'b0;
		end else if (in_valid && !in_ready) begin
		end else if (waiting) begin
			in_valid <= 1'b0;
			if (expected_solutions.size() == 0) waiting <= 1'b0;
		end else if (gap > 0) begin
			in_valid <= 1'b0;
			gap <= gap - 1;
		end else if (pending_words.size() > 0) begin
			w_drive = pending_words.pop_front();
			solve_word(w_drive);
			in_valid <= 1'b1;
			first_of_solve <= w_drive.first;
			has_coeff <= w_drive.has_c;
			column <= w_drive.col;
			coeff <= w_drive.cf;
			last_of_row <= w_drive.last;
			row <= w_drive.rw;
			rhs <= w_drive.rh;
			diag <= w_drive.dg;
			waiting <= w_drive.pause;
			gap <= gap_len();
		end else begin
			in_valid <= 1'b0;
			stim_done <= 1'b1;
		end
	end

	bit force_stall = 1'b0;
	bit stalled_once = 1'b0;

	// receiver
	always @(posedge clk or negedge arst_n) begin
		sol_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_solutions.size() == 0) begin
					$error("unexpected word: out_row %0d", out_row);
					errors++;
				end else begin
					e = expected_solutions.pop_front();
					if (out_row !== e.rw) begin
						$error("out_row: expected %0d, actual %0d", e.rw, out_row);
						errors++;
					end
					if (solution !== e.x) begin
						$error("solution: expected %h, actual %h", e.x, solution);
						errors++;
					end
					if (zero_diag !== e.zd) begin
						$error("zero_diag: expected %b, actual %b", e.zd, zero_diag);
						errors++;
					end
					if (saturated !== e.sat) begin
						$error("saturated: expected %b, actual %b", e.sat, saturated);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else if (force_stall && !stalled_once) begin
				stalled_once <= 1'b1;
				hold_off <= 2000;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 399) == 0) begin
				hold_off <= $urandom_range(500, 1500);
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(0, 3) != 0;
			end
		end
	end

	// long receiver stall early in the random part
	initial begin
		repeat (3000) @(posedge clk);
		force_stall = 1'b1;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && expected_solutions.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#4ms;
		$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
